// ===== design/pairwise_attraction_particle_step_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the particle step block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_ATTRACTION_PARTICLE_STEP_DEFINES_SVH
`define PAIRWISE_ATTRACTION_PARTICLE_STEP_DEFINES_SVH

// condition holds at every clock edge
`define PAP_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pap check failed");

// consequence holds in the cycle of the antecedent
`define PAP_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pap implication failed");

`endif

// ===== design/pap_pkg.sv =====
// ----------------------------------------------------------------------------
// pap_pkg
// Types and constants shared by the particle step controller and datapath.
// ----------------------------------------------------------------------------
package pap_pkg;

    localparam int SqrtSteps   = 20;  // root of a 40-bit square
    localparam int Div1Steps   = 29;  // unit component quotient bits
    localparam int Div2Steps   = 45;  // gain quotient bits
    localparam int ReportLimit = 64;
    localparam int IterW       = 6;

    localparam logic [11:0] AreaWidthRst  = 12'd800;
    localparam logic [11:0] AreaHeightRst = 12'd600;
    localparam logic [11:0] RangeRst      = 12'd100;

    localparam logic [1:0] CfgAreaWidth  = 2'd0;
    localparam logic [1:0] CfgAreaHeight = 2'd1;
    localparam logic [1:0] CfgRange      = 2'd2;

    localparam logic CmdAdd = 1'b0;

    localparam logic [1:0] StsAdded  = 2'd0;
    localparam logic [1:0] StsFull   = 2'd1;
    localparam logic [1:0] StsReport = 2'd2;
    localparam logic [1:0] StsEmpty  = 2'd3;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [7:0]         radius;
    } t_part;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD, S_LIM, S_RD_I, S_LOAD_I, S_JCHK, S_DIFF, S_SQ, S_SUM,
        S_TEST, S_SQRT, S_DD, S_D1I, S_D1, S_MRR, S_D2, S_ACC, S_MOVE, S_POS,
        S_WB, S_CPRD, S_CPWR, S_EMPTY, S_RPRD, S_RPOUT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LATCH, DP_ADD, DP_FULL, DP_LIM, DP_LOAD_I, DP_DIFF, DP_SQ,
        DP_SUM, DP_SQRT, DP_DD, DP_DIV1_INIT, DP_DIV1, DP_MUL_RR, DP_DIV2,
        DP_ACC, DP_MOVE, DP_POS, DP_WB, DP_CP_WR, DP_EMPTY, DP_REPORT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   axis;   // 0 x, 1 y
        logic   last;   // final report of a tick
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic skip;     // pair out of range or coincident
        logic alive;    // read particle has nonzero radius
    } t_dp_stat;

endpackage

// ===== design/pap_ctrl.sv =====
// ----------------------------------------------------------------------------
// pap_ctrl
// Sequencer for adds, the pairwise tick loop, compaction and reporting.
// ----------------------------------------------------------------------------
`include "pairwise_attraction_particle_step_defines.svh"

module pap_ctrl #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic [0:0]                         i_s_tuser,
    output logic                               o_s_tready,
    output pap_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(MAX_PARTICLES)-1:0]   o_rd_addr,
    output logic [$clog2(MAX_PARTICLES)-1:0]   o_wr_addr,
    input  pap_pkg::t_dp_stat                  i_stat
);
    import pap_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_live, n_live;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_w, n_w;
    logic [IterW-1:0] r_cnt, n_cnt;
    logic            r_axis, n_axis;
    logic            w_full;
    logic            w_rep_last;
    logic            w_out_load;

    assign w_full = (r_live >= CW'(MAX_PARTICLES));
    assign w_rep_last = (32'(r_i) + 32'd1 == 32'(r_live)) ||
                        (32'(r_i) + 32'd1 == 32'(ReportLimit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_w       <= '0;
            r_cnt     <= '0;
            r_axis    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_i       <= n_i;
            r_j       <= n_j;
            r_w       <= n_w;
            r_cnt     <= n_cnt;
            r_axis    <= n_axis;
        end
    end

    // next state and counters
    always_comb begin
        n_state   = r_state;
        n_live    = r_live;
        n_i       = r_i;
        n_j       = r_j;
        n_w       = r_w;
        n_cnt     = r_cnt;
        n_axis    = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state   = (i_s_tuser[0] == CmdAdd) ? S_ADD : S_LIM;
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    if (!w_full) begin
                        n_live = r_live + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_LIM: begin
                n_i = '0;
                n_w = '0;
                n_state = (r_live == '0) ? S_CPRD : S_RD_I;
            end
            S_RD_I: begin
                n_j = '0;
                n_state = S_LOAD_I;
            end
            S_LOAD_I: n_state = S_JCHK;
            S_JCHK: begin
                if (r_j == r_live) begin
                    n_state = S_MOVE;
                end else if (r_j == r_i) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_TEST;
            S_TEST: begin
                if (i_stat.skip) begin
                    n_j = r_j + CW'(1);
                    n_state = S_JCHK;
                end else begin
                    n_cnt = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_cnt = r_cnt + IterW'(1);
                if (r_cnt == IterW'(SqrtSteps - 1)) begin
                    n_state = S_DD;
                end
            end
            S_DD: begin
                n_axis = 1'b0;
                n_state = S_D1I;
            end
            S_D1I: begin
                n_cnt = '0;
                n_state = S_D1;
            end
            S_D1: begin
                n_cnt = r_cnt + IterW'(1);
                if (r_cnt == IterW'(Div1Steps - 1)) begin
                    n_state = S_MRR;
                end
            end
            S_MRR: begin
                n_cnt = '0;
                n_state = S_D2;
            end
            S_D2: begin
                n_cnt = r_cnt + IterW'(1);
                if (r_cnt == IterW'(Div2Steps - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (!r_axis) begin
                    n_axis = 1'b1;
                    n_state = S_D1I;
                end else begin
                    n_j = r_j + CW'(1);
                    n_state = S_JCHK;
                end
            end
            S_MOVE: n_state = S_POS;
            S_POS:  n_state = S_WB;
            S_WB: begin
                if (r_i + CW'(1) == r_live) begin
                    n_i = '0;
                    n_w = '0;
                    n_state = S_CPRD;
                end else begin
                    n_i = r_i + CW'(1);
                    n_state = S_RD_I;
                end
            end
            S_CPRD: begin
                if (r_i == r_live) begin
                    n_live = r_w;
                    n_i = '0;
                    n_state = (r_w == '0) ? S_EMPTY : S_RPRD;
                end else begin
                    n_state = S_CPWR;
                end
            end
            S_CPWR: begin
                if (i_stat.alive) begin
                    n_w = r_w + CW'(1);
                end
                n_i = r_i + CW'(1);
                n_state = S_CPRD;
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RPRD: n_state = S_RPOUT;
            S_RPOUT: begin
                if (i_stat.out_free) begin
                    if (w_rep_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + CW'(1);
                        n_state = S_RPRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd.op   = DP_NOP;
        o_cmd.axis = r_axis;
        o_cmd.last = w_rep_last;
        o_rd_addr  = r_i[AW-1:0];
        o_wr_addr  = r_i[AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = DP_LATCH;
                end
            end
            S_ADD: begin
                o_wr_addr = r_live[AW-1:0];
                if (i_stat.out_free) begin
                    o_cmd.op = w_full ? DP_FULL : DP_ADD;
                end
            end
            S_LIM:    o_cmd.op = DP_LIM;
            S_LOAD_I: o_cmd.op = DP_LOAD_I;
            S_JCHK:   o_rd_addr = r_j[AW-1:0];
            S_DIFF:   o_cmd.op = DP_DIFF;
            S_SQ:     o_cmd.op = DP_SQ;
            S_SUM:    o_cmd.op = DP_SUM;
            S_SQRT:   o_cmd.op = DP_SQRT;
            S_DD:     o_cmd.op = DP_DD;
            S_D1I:    o_cmd.op = DP_DIV1_INIT;
            S_D1:     o_cmd.op = DP_DIV1;
            S_MRR:    o_cmd.op = DP_MUL_RR;
            S_D2:     o_cmd.op = DP_DIV2;
            S_ACC:    o_cmd.op = DP_ACC;
            S_MOVE:   o_cmd.op = DP_MOVE;
            S_POS:    o_cmd.op = DP_POS;
            S_WB:     o_cmd.op = DP_WB;
            S_CPWR: begin
                o_wr_addr = r_w[AW-1:0];
                if (i_stat.alive) begin
                    o_cmd.op = DP_CP_WR;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_EMPTY;
                end
            end
            S_RPOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_REPORT;
                end
            end
            default: o_cmd.op = DP_NOP;
        endcase
    end

    assign w_out_load = (o_cmd.op == DP_ADD) || (o_cmd.op == DP_FULL) ||
                        (o_cmd.op == DP_EMPTY) || (o_cmd.op == DP_REPORT);

    `PAP_CHECK(a_live_bound, r_live <= CW'(MAX_PARTICLES))
    `PAP_IMPLY(a_out_load_free, w_out_load, i_stat.out_free)
    `PAP_IMPLY(a_compact_order, (r_state == S_CPRD || r_state == S_CPWR), r_w <= r_i)

endmodule

// ===== design/pap_dp.sv =====
// ----------------------------------------------------------------------------
// pap_dp
// Particle store, pairwise gain arithmetic, motion update and result register.
// ----------------------------------------------------------------------------
module pap_dp #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pap_pkg::t_dp_cmd                   i_cmd,
    input  logic [$clog2(MAX_PARTICLES)-1:0]   i_rd_addr,
    input  logic [$clog2(MAX_PARTICLES)-1:0]   i_wr_addr,
    output pap_pkg::t_dp_stat                  o_stat,
    input  logic [55:0]                        i_s_tdata,
    input  logic                               i_cfg_valid,
    input  logic [1:0]                         i_cfg_index,
    input  logic [11:0]                        i_cfg_data,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [55:0]                        o_m_tdata,
    output logic [1:0]                         o_m_tuser,
    output logic                               o_m_tlast
);
    import pap_pkg::*;

    t_part r_mem [MAX_PARTICLES];
    t_part r_rdata;
    t_part w_wdata;
    logic  w_we;

    logic [11:0] r_area_w, r_area_h, r_range;
    logic [11:0] r_sx, r_sy;
    logic [7:0]  r_sr;
    logic [16:0] r_dte;

    logic signed [23:0] r_xi, r_yi;
    logic signed [31:0] r_vx, r_vy;
    logic [7:0]         r_ri;
    logic signed [24:0] r_dx, r_dy;
    logic [15:0]        r_rr;
    logic [49:0]        r_sqx, r_sqy;
    logic [50:0]        r_d2;
    logic [39:0]        r_lim;
    logic [39:0]        r_src;
    logic [21:0]        r_srem;
    logic [19:0]        r_root;
    logic [39:0]        r_dd;
    logic [20:0]        r_rem1;
    logic [28:0]        r_q1;
    logic [44:0]        r_p;
    logic [39:0]        r_rem2;
    logic [48:0]        r_mx, r_my;

    logic        r_out_valid;
    logic [1:0]  r_out_sts;
    logic [5:0]  r_out_slot;
    logic [19:0] r_out_x, r_out_y;
    logic [7:0]  r_out_r;
    logic        r_out_last;

    logic [24:0] w_adx, w_ady;
    logic [19:0] w_rng;
    logic [50:0] w_sum;
    logic [23:0] w_sq_cur, w_sq_trial, w_sq_diff;
    logic        w_sq_ge;
    logic        w_ge1;
    logic [20:0] w_t1;
    logic [40:0] w_n2, w_t2;
    logic        w_ge2;
    logic [31:0] w_g;
    logic        w_neg;
    logic signed [31:0] w_vsel, w_vnew;
    logic signed [33:0] w_gs, w_acc;
    logic [31:0] w_avx, w_avy;
    logic        w_dead;

    function automatic logic signed [23:0] move_sat(input logic signed [23:0] pos,
                                                    input logic neg,
                                                    input logic [28:0] m);
        logic signed [29:0] t;
        logic signed [29:0] ms;
        ms = $signed({1'b0, m});
        t = 30'(pos) + (neg ? -ms : ms);
        if (t[29:23] == 7'h00 || t[29:23] == 7'h7f) begin
            return t[23:0];
        end else if (t[29]) begin
            return 24'sh800000;
        end else begin
            return 24'sh7fffff;
        end
    endfunction

    assign w_adx = r_dx[24] ? (25'd0 - $unsigned(r_dx)) : $unsigned(r_dx);
    assign w_ady = r_dy[24] ? (25'd0 - $unsigned(r_dy)) : $unsigned(r_dy);
    assign w_rng = {r_range, 8'h00};
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    // one root bit per step, two radicand bits in
    assign w_sq_cur   = {r_srem, r_src[39:38]};
    assign w_sq_trial = {2'b00, r_root, 2'b01};
    assign w_sq_ge    = (w_sq_cur >= w_sq_trial);
    assign w_sq_diff  = w_sq_cur - w_sq_trial;

    // |delta| * 2^28 / d: remainder starts at |delta| <= d
    assign w_ge1 = (r_rem1 >= {1'b0, r_root});
    assign w_t1  = w_ge1 ? (r_rem1 - {1'b0, r_root}) : r_rem1;

    // restoring divide, quotient shifts into r_p as dividend bits leave
    assign w_n2  = {r_rem2, r_p[44]};
    assign w_ge2 = (w_n2 >= {1'b0, r_dd});
    assign w_t2  = w_ge2 ? (w_n2 - {1'b0, r_dd}) : w_n2;

    assign w_g    = (r_p > 45'h0_8000_0000) ? 32'h8000_0000 : r_p[31:0];
    assign w_neg  = i_cmd.axis ? r_dy[24] : r_dx[24];
    assign w_vsel = i_cmd.axis ? r_vy : r_vx;
    assign w_gs   = w_neg ? -$signed({2'b00, w_g}) : $signed({2'b00, w_g});
    assign w_acc  = 34'(w_vsel) + w_gs;
    assign w_vnew = (w_acc[33:31] == 3'b000 || w_acc[33:31] == 3'b111) ? w_acc[31:0] :
                    (w_acc[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    assign w_avx = r_vx[31] ? (32'd0 - $unsigned(r_vx)) : $unsigned(r_vx);
    assign w_avy = r_vy[31] ? (32'd0 - $unsigned(r_vy)) : $unsigned(r_vy);

    assign w_dead = r_xi[23] || r_yi[23] ||
                    ($unsigned(r_xi[22:0]) > 23'({r_area_w, 8'h00})) ||
                    ($unsigned(r_yi[22:0]) > 23'({r_area_h, 8'h00}));

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_rdata;
        case (i_cmd.op)
            DP_ADD: begin
                w_we           = 1'b1;
                w_wdata.x      = $signed({4'h0, r_sx, 8'h00});
                w_wdata.y      = $signed({4'h0, r_sy, 8'h00});
                w_wdata.vx     = '0;
                w_wdata.vy     = '0;
                w_wdata.radius = r_sr;
            end
            DP_WB: begin
                w_we           = 1'b1;
                w_wdata.x      = r_xi;
                w_wdata.y      = r_yi;
                w_wdata.vx     = r_vx;
                w_wdata.vy     = r_vy;
                w_wdata.radius = w_dead ? 8'h00 : r_ri;
            end
            DP_CP_WR: w_we = 1'b1;
            default:  w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_wr_addr] <= w_wdata;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    // configuration and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w    <= AreaWidthRst;
            r_area_h    <= AreaHeightRst;
            r_range     <= RangeRst;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CfgAreaWidth:  r_area_w <= i_cfg_data;
                    CfgAreaHeight: r_area_h <= i_cfg_data;
                    CfgRange:      r_range  <= i_cfg_data;
                    default:       r_range  <= r_range;
                endcase
            end
            if (i_cmd.op == DP_ADD || i_cmd.op == DP_FULL ||
                i_cmd.op == DP_EMPTY || i_cmd.op == DP_REPORT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_sx  <= i_s_tdata[11:0];
                r_sy  <= i_s_tdata[23:12];
                r_sr  <= i_s_tdata[31:24];
                r_dte <= i_s_tdata[48] ? {i_s_tdata[47:32], 1'b0} : {1'b0, i_s_tdata[47:32]};
            end
            DP_ADD: begin
                r_out_sts  <= StsAdded;
                r_out_slot <= 6'(i_wr_addr);
                r_out_x    <= {r_sx, 8'h00};
                r_out_y    <= {r_sy, 8'h00};
                r_out_r    <= r_sr;
                r_out_last <= 1'b1;
            end
            DP_FULL, DP_EMPTY: begin
                r_out_sts  <= (i_cmd.op == DP_FULL) ? StsFull : StsEmpty;
                r_out_slot <= '0;
                r_out_x    <= '0;
                r_out_y    <= '0;
                r_out_r    <= '0;
                r_out_last <= 1'b1;
            end
            DP_REPORT: begin
                r_out_sts  <= StsReport;
                r_out_slot <= 6'(i_rd_addr);
                r_out_x    <= r_rdata.x[19:0];
                r_out_y    <= r_rdata.y[19:0];
                r_out_r    <= r_rdata.radius;
                r_out_last <= i_cmd.last;
            end
            DP_LIM: r_lim <= w_rng * w_rng;
            DP_LOAD_I: begin
                r_xi <= r_rdata.x;
                r_yi <= r_rdata.y;
                r_vx <= r_rdata.vx;
                r_vy <= r_rdata.vy;
                r_ri <= r_rdata.radius;
            end
            DP_DIFF: begin
                r_dx <= 25'(r_rdata.x) - 25'(r_xi);
                r_dy <= 25'(r_rdata.y) - 25'(r_yi);
                r_rr <= r_ri * r_rdata.radius;
            end
            DP_SQ: begin
                r_sqx <= w_adx * w_adx;
                r_sqy <= w_ady * w_ady;
            end
            DP_SUM: begin
                r_d2   <= w_sum;
                r_src  <= w_sum[39:0];
                r_srem <= '0;
                r_root <= '0;
            end
            DP_SQRT: begin
                r_src  <= {r_src[37:0], 2'b00};
                r_srem <= w_sq_ge ? w_sq_diff[21:0] : w_sq_cur[21:0];
                r_root <= {r_root[18:0], w_sq_ge};
            end
            DP_DD: r_dd <= r_root * r_root;
            DP_DIV1_INIT: begin
                r_rem1 <= i_cmd.axis ? w_ady[20:0] : w_adx[20:0];
                r_q1   <= '0;
            end
            DP_DIV1: begin
                r_rem1 <= {w_t1[19:0], 1'b0};
                r_q1   <= {r_q1[27:0], w_ge1};
            end
            DP_MUL_RR: begin
                r_p    <= r_q1 * r_rr;
                r_rem2 <= '0;
            end
            DP_DIV2: begin
                r_rem2 <= w_t2[39:0];
                r_p    <= {r_p[43:0], w_ge2};
            end
            DP_ACC: begin
                if (i_cmd.axis) begin
                    r_vy <= w_vnew;
                end else begin
                    r_vx <= w_vnew;
                end
            end
            DP_MOVE: begin
                r_mx <= w_avx * r_dte;
                r_my <= w_avy * r_dte;
            end
            DP_POS: begin
                r_xi <= move_sat(r_xi, r_vx[31], r_mx[48:20]);
                r_yi <= move_sat(r_yi, r_vy[31], r_my[48:20]);
            end
            default: r_sr <= r_sr;
        endcase
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_stat.skip     = (r_d2 == '0) || (r_d2 >= {11'h000, r_lim});
    assign o_stat.alive    = (r_rdata.radius != 8'h00);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_r, r_out_y, r_out_x, r_out_slot};
    assign o_m_tuser  = r_out_sts;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== design/pairwise_attraction_particle_step.sv =====
// ----------------------------------------------------------------------------
// pairwise_attraction_particle_step
// 2D particle store with direct-sum pairwise attraction, motion and culling.
// ----------------------------------------------------------------------------
// Add: command latched on acceptance; result registered when output is free.
// Tick: each pair within range runs a 20-step root and two 29-step and two
// 45-step divide passes, one of each per axis on dividers shared by x and y;
// then compaction and reports. One item at a time.
// Reset (synchronous, i_rst_n low) empties the store and loads the area and
// range registers with 800, 600 and 100.
module pairwise_attraction_particle_step #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [11:0] spawn_x, [23:12] spawn_y, [31:24] spawn_radius,
    // [47:32] time_step, [48] fast
    input  logic [55:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [5:0] slot, [25:6] report_x, [45:26] report_y, [53:46] report_radius
    output logic [55:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import pap_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic [AW-1:0] w_rd_addr, w_wr_addr;

    assign o_cfg_ready = 1'b1;

    pap_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_wr_addr  (w_wr_addr),
        .i_stat     (w_stat)
    );

    pap_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .i_wr_addr   (w_wr_addr),
        .o_stat      (w_stat),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
